@@ design/vnsrch_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vnsrch_pkg
// Shared widths, codes and controller/datapath interface types for the
// visible neighbor search block.
// ---------------------------------------------------------------------------
package vnsrch_pkg;

  localparam int MAX_AGENTS = 64;
  localparam int AGENT_W    = $clog2(MAX_AGENTS);
  localparam int COUNT_W    = 7;
  localparam int RADIUS_W   = 31;
  localparam int COS_W      = 16;
  localparam int POS_W      = 32;
  localparam int HEAD_W     = 16;
  localparam int ENTRY_W    = 2 * POS_W + 2 * HEAD_W;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  // Input item kinds.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd2;

  typedef struct packed {
    logic               mem_we;
    logic               rd_self;
    logic               load_self;
    logic               issue;
    logic [AGENT_W-1:0] addr;
    logic               finish;
  } vnsrch_cmd_t;

  typedef struct packed {
    logic               adv;
    logic               busy;
    logic [COUNT_W-1:0] n_used;
  } vnsrch_stat_t;

endpackage

@@ design/vnsrch_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vnsrch_ctrl
// Controller: accepts requests, stores writes, and sequences a query through
// self read, table sweep, pipeline drain and the final result.
// ---------------------------------------------------------------------------
module vnsrch_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_op,
  input  logic [vnsrch_pkg::AGENT_W-1:0]  in_idx,
  input  vnsrch_pkg::vnsrch_stat_t        stat,
  output vnsrch_pkg::vnsrch_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LDSELF,
    ST_SWEEP,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t                         state;
  logic [vnsrch_pkg::COUNT_W-1:0] cnt;
  logic [vnsrch_pkg::COUNT_W-1:0] n_q;
  logic [vnsrch_pkg::COUNT_W-1:0] cnt_next;
  logic                           accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign cnt_next = cnt + 7'd1;

  always_comb begin
    cmd.mem_we    = accept && (in_op == vnsrch_pkg::OP_WRITE);
    cmd.rd_self   = accept && (in_op == vnsrch_pkg::OP_QUERY);
    cmd.load_self = (state == ST_LDSELF);
    cmd.issue     = (state == ST_SWEEP);
    cmd.addr      = cnt[vnsrch_pkg::AGENT_W-1:0];
    cmd.finish    = (state == ST_FINISH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      n_q   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && (in_op == vnsrch_pkg::OP_QUERY)) begin
            cnt <= '0;
            n_q <= stat.n_used;
            // A queried agent outside the used range gets only the empty result.
            if ({1'b0, in_idx} < stat.n_used) state <= ST_LDSELF;
            else                              state <= ST_FINISH;
          end
        end
        ST_LDSELF: begin
          state <= ST_SWEEP;
        end
        ST_SWEEP: begin
          if (stat.adv) begin
            cnt <= cnt_next;
            if (cnt_next == n_q) state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!stat.busy) state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (stat.adv) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/vnsrch_dp.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vnsrch_dp
// Datapath: agent table, configuration registers, the seven-stage distance
// and vision cone pipeline, and the result register with one pending hit.
// ---------------------------------------------------------------------------
module vnsrch_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [vnsrch_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vnsrch_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [vnsrch_pkg::AGENT_W-1:0]     in_idx,
  input  logic [vnsrch_pkg::ENTRY_W-1:0]     in_entry,
  input  vnsrch_pkg::vnsrch_cmd_t            cmd,
  output vnsrch_pkg::vnsrch_stat_t           stat,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [vnsrch_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                               m_tlast
);

  localparam int AW = vnsrch_pkg::AGENT_W;

  // Configuration.
  logic [vnsrch_pkg::RADIUS_W-1:0] radius;
  logic signed [15:0]              cosv;
  logic [vnsrch_pkg::COUNT_W-1:0]  count;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= 31'd3276800;
      cosv   <= '0;
      count  <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        vnsrch_pkg::CFG_RADIUS: radius <= cfg_data;
        vnsrch_pkg::CFG_COS:    cosv   <= cfg_data[15:0];
        vnsrch_pkg::CFG_COUNT:  count  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic busy;
  assign adv         = !m_tvalid || m_tready;
  assign stat.adv    = adv;
  assign stat.busy   = busy;
  assign stat.n_used = (count > 7'(vnsrch_pkg::MAX_AGENTS)) ?
                       7'(vnsrch_pkg::MAX_AGENTS) : count;

  // Agent table: {head_y, head_x, pos_y, pos_x}.
  logic [vnsrch_pkg::ENTRY_W-1:0] mem [0:vnsrch_pkg::MAX_AGENTS-1];
  logic [vnsrch_pkg::ENTRY_W-1:0] rdata;
  logic [AW-1:0]                  rd_addr;
  logic [AW-1:0]                  idx0;
  logic                           rd_en;
  logic                           v0;

  assign rd_addr = cmd.rd_self ? in_idx : cmd.addr;
  assign rd_en   = cmd.rd_self || (cmd.issue && adv);

  always_ff @(posedge clk) begin
    if (cmd.mem_we) mem[in_idx] <= in_entry;
    if (rd_en) begin
      rdata <= mem[rd_addr];
      idx0  <= rd_addr;
    end
  end

  // Queried agent, held for the whole sweep.
  logic signed [31:0] sx, sy;
  logic signed [15:0] shx, shy;
  logic [AW-1:0]      self_idx;

  always_ff @(posedge clk) begin
    if (cmd.rd_self) self_idx <= in_idx;
    if (cmd.load_self) begin
      sx  <= rdata[31:0];
      sy  <= rdata[63:32];
      shx <= rdata[79:64];
      shy <= rdata[95:80];
    end
  end

  // Per-query constants: radius^2 and cos^2 * |h|^2.
  logic signed [31:0] hxe, hye, ce, hxx_w, hyy_w, csq_w;
  logic [30:0]        hxx, hyy, csq;
  logic [31:0]        hsq;
  logic [63:0]        bsq_w, r2_w;
  logic [61:0]        bsq, r2;

  assign hxe   = 32'(shx);
  assign hye   = 32'(shy);
  assign ce    = 32'(cosv);
  assign hxx_w = hxe * hxe;
  assign hyy_w = hye * hye;
  assign csq_w = ce * ce;
  assign bsq_w = 64'(csq) * 64'(hsq);
  assign r2_w  = 64'(radius) * 64'(radius);

  always_ff @(posedge clk) begin
    hxx <= hxx_w[30:0];
    hyy <= hyy_w[30:0];
    csq <= csq_w[30:0];
    hsq <= {1'b0, hxx} + {1'b0, hyy};
    bsq <= bsq_w[61:0];
    r2  <= r2_w[61:0];
  end

  // Stage 1: offsets.
  logic signed [32:0] ox_e, oy_e, dx_w, dy_w, dx1, dy1;
  logic [AW-1:0]      idx1;
  logic               v1;

  assign ox_e = 33'($signed(rdata[31:0]));
  assign oy_e = 33'($signed(rdata[63:32]));
  assign dx_w = ox_e - 33'(sx);
  assign dy_w = oy_e - 33'(sy);

  always_ff @(posedge clk) begin
    if (adv) begin
      dx1  <= dx_w;
      dy1  <= dy_w;
      idx1 <= idx0;
    end
  end

  // Stage 2: box test, squares and heading products.
  logic [32:0]        adx_w, ady_w;
  logic [61:0]        sqx_w, sqy_w, ax2, ay2;
  logic signed [48:0] dx_e, dy_e, hx_e, hy_e, pxh_w, pyh_w, pxh, pyh;
  logic               near_w, near2, v2;
  logic [AW-1:0]      idx2;

  assign adx_w  = dx1[32] ? 33'(-dx1) : 33'(dx1);
  assign ady_w  = dy1[32] ? 33'(-dy1) : 33'(dy1);
  assign near_w = (adx_w < 33'(radius)) && (ady_w < 33'(radius));
  assign sqx_w  = 62'(adx_w[30:0]) * 62'(adx_w[30:0]);
  assign sqy_w  = 62'(ady_w[30:0]) * 62'(ady_w[30:0]);
  assign dx_e   = 49'(dx1);
  assign dy_e   = 49'(dy1);
  assign hx_e   = 49'(shx);
  assign hy_e   = 49'(shy);
  assign pxh_w  = dx_e * hx_e;
  assign pyh_w  = dy_e * hy_e;

  always_ff @(posedge clk) begin
    if (adv) begin
      ax2   <= sqx_w;
      ay2   <= sqy_w;
      pxh   <= pxh_w;
      pyh   <= pyh_w;
      near2 <= near_w;
      idx2  <= idx1;
    end
  end

  // Stage 3: squared distance, radius test, dot product.
  logic [62:0]        v_w, v3;
  logic signed [49:0] dot_w, dot3;
  logic               near3, v3q;
  logic [AW-1:0]      idx3;

  assign v_w   = {1'b0, ax2} + {1'b0, ay2};
  assign dot_w = 50'(pxh) + 50'(pyh);

  always_ff @(posedge clk) begin
    if (adv) begin
      v3    <= v_w;
      dot3  <= dot_w;
      near3 <= near2 && (v_w < {1'b0, r2});
      idx3  <= idx2;
    end
  end

  // Stage 4: partial products of dot^2 and cos^2 * |h|^2 * |v|^2.
  logic [49:0] adot;
  logic [23:0] al;
  logic [22:0] ah;
  logic [47:0] pll;
  logic [46:0] plh;
  logic [45:0] phh;
  logic [63:0] p00;
  logic [62:0] p01;
  logic [61:0] p10;
  logic [60:0] p11;
  logic        neg4, near4, v4;
  logic [AW-1:0] idx4;

  // A dot that passes the radius test fits in 47 bits.
  assign adot = dot3[49] ? 50'(-dot3) : 50'(dot3);
  assign al   = adot[23:0];
  assign ah   = adot[46:24];

  always_ff @(posedge clk) begin
    if (adv) begin
      pll   <= 48'(al) * 48'(al);
      plh   <= 47'(al) * 47'(ah);
      phh   <= 46'(ah) * 46'(ah);
      p00   <= 64'(bsq[31:0]) * 64'(v3[31:0]);
      p01   <= 63'(bsq[31:0]) * 63'(v3[62:32]);
      p10   <= 62'(bsq[61:32]) * 62'(v3[31:0]);
      p11   <= 61'(bsq[61:32]) * 61'(v3[62:32]);
      neg4  <= dot3[49];
      near4 <= near3;
      idx4  <= idx3;
    end
  end

  // Stage 5: assemble both sides of the cone inequality.
  logic [93:0]  a5;
  logic [125:0] r5;
  logic         neg5, near5, v5;
  logic [AW-1:0] idx5;

  always_ff @(posedge clk) begin
    if (adv) begin
      a5    <= (94'(phh) << 48) + (94'(plh) << 25) + 94'(pll);
      r5    <= (126'(p11) << 64) + ((126'(p01) + 126'(p10)) << 32) + 126'(p00);
      neg5  <= neg4;
      near5 <= near4;
      idx5  <= idx4;
    end
  end

  // Stage 6: cone decision.
  logic [125:0] l5;
  logic         pass_w, hit6, v6;
  logic [AW-1:0] idx6;

  assign l5     = {4'b0, a5, 28'b0};
  assign pass_w = cosv[15] ? (!neg5 || (r5 >= l5)) : (!neg5 && (l5 >= r5));

  always_ff @(posedge clk) begin
    if (adv) begin
      hit6 <= near5 && pass_w && (idx5 != self_idx);
      idx6 <= idx5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3q <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (adv) begin
      v0  <= cmd.issue;
      v1  <= v0;
      v2  <= v1;
      v3q <= v2;
      v4  <= v3q;
      v5  <= v4;
      v6  <= v5;
    end
  end

  assign busy = v0 || v1 || v2 || v3q || v4 || v5 || v6;

  // One hit is held back so that the final one can carry last.
  logic          pend_v;
  logic [AW-1:0] pend_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      pend_v   <= 1'b0;
    end else if (adv) begin
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {1'b0, pend_v, pend_v ? pend_idx : {AW{1'b0}}};
        m_tlast  <= 1'b1;
        pend_v   <= 1'b0;
      end else if (v6 && hit6) begin
        m_tvalid <= pend_v;
        m_tdata  <= {1'b0, 1'b1, pend_idx};
        m_tlast  <= 1'b0;
        pend_v   <= 1'b1;
        pend_idx <= idx6;
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

@@ design/visible_neighbor_search_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// visible_neighbor_search_top
// Fixed-radius neighbor search with a field-of-view test over an agent table.
// ---------------------------------------------------------------------------
// A write request (tuser 0) stores one table entry. A query request
// (tuser 1) reads the queried agent, then sweeps entries 0 to N-1 at one
// entry per cycle through a seven-stage distance and cone pipeline, where N
// is min(agent_count, 64); the sweep pauses while a result waits. Hits leave
// in ascending index order, the final one with tlast; a query with no hit
// gives one result with found clear. Table entries must be written before
// any query reads them. New requests are taken once the final result of the
// previous query sits in the output register.
module visible_neighbor_search_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // agent_index[5:0], pos_x[37:6], pos_y[69:38], head_x[85:70],
  // head_y[101:86], zero pad[103:102]
  input  logic [vnsrch_pkg::IN_DATA_W-1:0]   s_tdata,
  // operation
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // neighbor_index[5:0], found[6], zero pad[7]
  output logic [vnsrch_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                               m_tlast,
  input  logic                               cfg_we,
  input  logic [vnsrch_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vnsrch_pkg::CFG_DATA_W-1:0]  cfg_data
);

  vnsrch_pkg::vnsrch_cmd_t  cmd;
  vnsrch_pkg::vnsrch_stat_t stat;

  vnsrch_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (s_tuser),
    .in_idx   (s_tdata[5:0]),
    .stat     (stat),
    .cmd      (cmd)
  );

  vnsrch_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_idx    (s_tdata[5:0]),
    .in_entry  (s_tdata[101:6]),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

@@ design/vnsrch_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vnsrch_checker
// Port-level checks on the visible neighbor search block.
// ---------------------------------------------------------------------------
module vnsrch_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic                               s_tuser,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [vnsrch_pkg::OUT_DATA_W-1:0]  m_tdata,
  input logic                               m_tlast
);

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // An empty result always closes the query.
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[6] |-> m_tlast)
    else $error("empty result without last");

  // Once a query request is taken, s_tready drops.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("request taken during a query");

  // The block is not ready for requests while a result without last is taken.
  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |-> !s_tready)
    else $error("request taken with results still pending");

endmodule

bind visible_neighbor_search_top vnsrch_checker u_chk (.*);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for visible_neighbor_search_top: writes agent tables,
// issues neighbor queries and checks every hit against an internal predictor.
// ---------------------------------------------------------------------------
module testbench;

  typedef struct {
    logic              op;
    logic [5:0]        agent;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] hx;
    logic signed [15:0] hy;
  } agent_req_t;

  typedef struct {
    logic [5:0] nbr;
    logic       found;
    logic       last;
  } hit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [vnsrch_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [vnsrch_pkg::OUT_DATA_W-1:0] m_tdata;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic [vnsrch_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [vnsrch_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  always #2 clk = ~clk;

  visible_neighbor_search_top i_dut (.*);

  agent_req_t pending_reqs[$];
  hit_t expected_hits[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles = 0;
  int queries_sent = 0;
  int hits_seen = 0;

  // Acceptance flag from the last rising edge so the driver knows to advance.
  bit s_tready_seen = 1'b0;

  // Predictor copy of the agent table and registers.
  logic signed [31:0] tbl_x[vnsrch_pkg::MAX_AGENTS];
  logic signed [31:0] tbl_y[vnsrch_pkg::MAX_AGENTS];
  logic signed [15:0] tbl_hx[vnsrch_pkg::MAX_AGENTS];
  logic signed [15:0] tbl_hy[vnsrch_pkg::MAX_AGENTS];
  logic [30:0] radius_q = 31'd3276800;
  logic signed [15:0] cosv_q = '0;
  logic [6:0] count_q = 7'd64;

  function automatic bit agent_sees(int self, int other);
    logic signed [33:0] dx, dy;
    logic [33:0] adx, ady;
    logic [67:0] dist2, rad2;
    logic signed [53:0] dot;
    logic [53:0] adot;
    logic [255:0] lhs, rhs, hh, cc;
    dx = 34'(tbl_x[other]) - 34'(tbl_x[self]);
    dy = 34'(tbl_y[other]) - 34'(tbl_y[self]);
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    dist2 = 68'(adx) * adx + 68'(ady) * ady;
    rad2 = 68'(radius_q) * radius_q;
    if (dist2 >= rad2) return 1'b0;
    dot = 54'(dx) * tbl_hx[self] + 54'(dy) * tbl_hy[self];
    adot = dot < 0 ? -dot : dot;
    lhs = (256'(adot) << 14) * (256'(adot) << 14);
    hh = 256'(34'(tbl_hx[self]) * tbl_hx[self] + 34'(tbl_hy[self]) * tbl_hy[self]);
    cc = 256'(34'(cosv_q) * cosv_q);
    rhs = cc * hh * 256'(dist2);
    if (cosv_q >= 0) return dot >= 0 && lhs >= rhs;
    return dot >= 0 || rhs >= lhs;
  endfunction

  function automatic void predict_request(agent_req_t r);
    int n, cnt;
    hit_t h;
    if (r.op == vnsrch_pkg::OP_WRITE) begin
      tbl_x[r.agent] = r.px;
      tbl_y[r.agent] = r.py;
      tbl_hx[r.agent] = r.hx;
      tbl_hy[r.agent] = r.hy;
      return;
    end
    n = count_q < vnsrch_pkg::MAX_AGENTS ? count_q : vnsrch_pkg::MAX_AGENTS;
    cnt = 0;
    if (r.agent < n) begin
      for (int i = 0; i < n; i++) begin
        if (i != r.agent && agent_sees(r.agent, i)) begin
          h.nbr = 6'(i);
          h.found = 1'b1;
          h.last = 1'b0;
          expected_hits = {expected_hits, h};
          cnt++;
        end
      end
    end
    if (cnt == 0) begin
      h.nbr = '0;
      h.found = 1'b0;
      h.last = 1'b1;
      expected_hits = {expected_hits, h};
    end else begin
      expected_hits[$].last = 1'b1;
    end
  endfunction

  // Driver: takes requests from the pending queue at falling edges.
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || s_tready_seen) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          agent_req_t r;
          r = pending_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= r.op;
          s_tdata <= {2'b00, r.hy, r.hx, r.py, r.px, r.agent};
          predict_request(r);
          if (r.op == vnsrch_pkg::OP_QUERY) queries_sent++;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor and watchdog.
  always @(posedge clk) begin
    s_tready_seen <= s_tvalid && s_tready;
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 5000) begin
          $display("tb: failure");
          $finish;
        end
      end
      if (m_tvalid && m_tready) begin
        hits_seen++;
        if (expected_hits.size() == 0) begin
          $error("unexpected result: neighbor_index %0d", m_tdata[5:0]);
          errors++;
        end else begin
          hit_t e;
          e = expected_hits.pop_front();
          if (m_tdata[5:0] !== e.nbr) begin
            $error("neighbor_index: expected %0d, actual %0d", e.nbr, m_tdata[5:0]);
            errors++;
          end
          if (m_tdata[6] !== e.found) begin
            $error("found: expected %0d, actual %0d", e.found, m_tdata[6]);
            errors++;
          end
          if (m_tlast !== e.last) begin
            $error("last: expected %0d, actual %0d", e.last, m_tlast);
            errors++;
          end
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || s_tvalid || expected_hits.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [vnsrch_pkg::CFG_IDX_W-1:0] idx, logic [30:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == vnsrch_pkg::CFG_RADIUS) radius_q = val;
    else if (idx == vnsrch_pkg::CFG_COS) cosv_q = val[15:0];
    else if (idx == vnsrch_pkg::CFG_COUNT) count_q = val[6:0];
  endtask

  function automatic void add_write(int a, logic [31:0] x, logic [31:0] y,
                                    logic [15:0] hx, logic [15:0] hy);
    agent_req_t r;
    r.op = vnsrch_pkg::OP_WRITE;
    r.agent = 6'(a);
    r.px = x;
    r.py = y;
    r.hx = hx;
    r.hy = hy;
    pending_reqs = {pending_reqs, r};
  endfunction

  function automatic void add_query(int a);
    agent_req_t r;
    r.op = vnsrch_pkg::OP_QUERY;
    r.agent = 6'(a);
    r.px = $urandom;
    r.py = $urandom;
    r.hx = 16'($urandom);
    r.hy = 16'($urandom);
    pending_reqs = {pending_reqs, r};
  endfunction

  // A heading from a few unit and extreme directions, sometimes fully random.
  function automatic logic [15:0] rand_head();
    case ($urandom_range(5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      3: return 16'($urandom);
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  // Agents clustered around a point so that many fall inside the radius.
  task automatic fill_cluster(int span);
    logic [31:0] cx, cy;
    cx = $urandom;
    cy = $urandom;
    cx[31] = 1'b0;
    cy[31] = 1'b0;
    cx = cx >> 2;
    cy = cy >> 2;
    for (int i = 0; i < vnsrch_pkg::MAX_AGENTS; i++)
      add_write(i, 32'(cx + $urandom_range(span) - span / 2),
                32'(cy + $urandom_range(span) - span / 2), rand_head(), rand_head());
  endtask

  task automatic random_phase(int n_items, int span);
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(3) == 0)
        add_write($urandom_range(63), $urandom, $urandom, 16'($urandom), 16'($urandom));
      else if ($urandom_range(2) == 0)
        add_write($urandom_range(63), 32'(32'h2000_0000 + $urandom_range(span)),
                  32'(32'h2000_0000 + $urandom_range(span)), rand_head(), rand_head());
      else
        add_query($urandom_range(63));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extreme positions and headings, coincident centres, zero heading.
    add_write(0, 32'h0, 32'h0, 16'sd16384, 16'sd0);
    add_write(1, 32'h0, 32'h0, 16'sd0, 16'sd0);
    add_write(2, 32'h0001_0000, 32'h0, -16'sd16384, 16'sd16384);
    add_write(3, 32'hFFFF_0000, 32'h0, 16'sd0, -16'sd16384);
    add_write(4, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 16'h8000);
    add_write(5, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF, 16'h0001);
    for (int i = 6; i < vnsrch_pkg::MAX_AGENTS; i++)
      add_write(i, 32'(i) << 15, -(32'(i) << 14), rand_head(), rand_head());
    add_query(0);
    add_query(1);
    add_query(4);
    add_query(63);
    send_idle_pct = 21;
    recv_idle_pct = 72;
    wait_drained();

    // Empty queries: count of zero, query beyond count, then one agent in use.
    write_reg(vnsrch_pkg::CFG_COUNT, 31'd0);
    add_query(0);
    wait_drained();
    write_reg(vnsrch_pkg::CFG_COUNT, 31'd3);
    add_query(5);
    add_query(2);
    wait_drained();
    write_reg(vnsrch_pkg::CFG_COUNT, 31'd1);
    add_query(0);
    wait_drained();
    write_reg(vnsrch_pkg::CFG_COUNT, 31'd127);
    write_reg(vnsrch_pkg::CFG_RADIUS, 31'h7FFF_FFFF);
    write_reg(vnsrch_pkg::CFG_COS, 31'(16'h8000));
    add_query(2);
    add_query(5);
    wait_drained();
    write_reg(vnsrch_pkg::CFG_COS, 31'(16'sd16384));
    write_reg(vnsrch_pkg::CFG_RADIUS, 31'd0);
    add_query(3);
    wait_drained();

    // Random phases across several register settings.
    write_reg(vnsrch_pkg::CFG_RADIUS, 31'h0040_0000);
    write_reg(vnsrch_pkg::CFG_COS, 31'(16'sd11585));
    write_reg(vnsrch_pkg::CFG_COUNT, 31'd64);
    fill_cluster(32'h0060_0000);
    random_phase(30, 32'h0080_0000);
    wait_drained();

    send_idle_pct = 72;
    recv_idle_pct = 21;
    write_reg(vnsrch_pkg::CFG_COS, 31'(-16'sd8192));
    write_reg(vnsrch_pkg::CFG_COUNT, 31'd17);
    random_phase(25, 32'h0080_0000);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(vnsrch_pkg::CFG_RADIUS, 31'h7FFF_FFFF);
    write_reg(vnsrch_pkg::CFG_COS, 31'(16'h7FFF));
    write_reg(vnsrch_pkg::CFG_COUNT, 31'd64);
    random_phase(25, 32'h4000_0000);
    wait_drained();

    $display("tb: covered %0d queries and %0d results over several radius, cone and count",
             queries_sent, hits_seen);
    $display("tb: settings, including zero count, zero radius and both cosine extremes");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
